// File: sv/rusi_pkg.sv
// ----------------------------------------------------------------------------
// rusi_pkg
// Shared defaults and width helpers for the ray / unit sphere intersect core.
// ----------------------------------------------------------------------------
`default_nettype none

package rusi_pkg;

    // default number format: signed Q16.16 in a 32-bit word
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // A, B and C as signed words (A is never negative)
    function automatic int xw(input int w);
        return 2 * w + 1;
    endfunction

    // discriminant B*B - A*C, signed
    function automatic int dw(input int w);
        return 4 * w + 2;
    endfunction

    // radicand D << 2F, padded to an even width
    function automatic int nw(input int w, input int f);
        return 4 * w + 2 + 2 * f;
    endfunction

    // square root width
    function automatic int rw(input int w, input int f);
        return 2 * w + 1 + f;
    endfunction

    // numerators -B*2^F -/+ R, signed
    function automatic int nnw(input int w, input int f);
        return 2 * w + f + 3;
    endfunction

endpackage : rusi_pkg

`default_nettype wire

// File: sv/ray_unit_sphere_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_unit_sphere_intersect_core
// Intersects one ray per transfer with the unit sphere at the origin.
// ----------------------------------------------------------------------------
// Fully pipelined: a ray is accepted in every cycle in which the output side
// is not stalled. Each ray passes through the front end, the bit-serial
// square root (one bit of sqrt(D * 2^2F) per stage), a numerator register
// and the two floor dividers by A (one quotient bit per stage); the words
// are signed Q16.16 by default. A stall on the output freezes the whole
// pipeline; nothing is dropped. Misses (D <= 0) come out with the hit flag
// low and both parameters zero.
`default_nettype none

module ray_unit_sphere_intersect_core #(
    parameter int WORD_BITS = rusi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rusi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((6*WORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // near_t, far_t
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*WORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // hit
    output logic                                   m_axis_tuser
);
    import rusi_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int XW  = xw(W);
    localparam int NW  = nw(W, F);
    localparam int RW  = rw(W, F);
    localparam int NNW = nnw(W, F);
    localparam int SW  = 1 + 2 * W + XW;
    localparam int OW  = ((2 * W + 7) / 8) * 8;

    logic en;

    logic signed [W-1:0] w_org [3];
    logic signed [W-1:0] w_dir [3];

    logic                 q_vld, q_hit;
    logic [NW-1:0]        q_n;
    logic [2*W-1:0]       q_a;
    logic signed [XW-1:0] q_b;

    logic                 s_vld;
    logic [RW-1:0]        s_root;
    logic [SW-1:0]        s_side;
    logic signed [XW-1:0] s_b;

    logic                  r_cvld;
    logic                  r_chit;
    logic [2*W-1:0]        r_ca;
    logic signed [NNW-1:0] r_nn, r_nf;
    logic signed [NNW-1:0] w_nb, w_r;

    logic                d_vld, d_hit;
    logic signed [W-1:0] d_near, d_far;

    // global advance: the output register is free or being emptied
    assign en            = !d_vld || m_axis_tready;
    assign s_axis_tready = en;

    // unpack the ray
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign w_org[i] = $signed(s_axis_tdata[i*W +: W]);
        assign w_dir[i] = $signed(s_axis_tdata[(i+3)*W +: W]);
    end

    rusi_quad #(.W(W), .F(F)) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_org   (w_org),
        .i_dir   (w_dir),
        .o_vld   (q_vld),
        .o_hit   (q_hit),
        .o_n     (q_n),
        .o_a     (q_a),
        .o_b     (q_b)
    );

    rusi_sqrt #(.W(W), .F(F), .SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (q_vld),
        .i_n     (q_n),
        .i_side  ({q_hit, q_a, q_b}),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // numerators -B*2^F -/+ R
    assign s_b  = $signed(s_side[XW-1:0]);
    assign w_nb = -(NNW'(s_b)) <<< F;
    assign w_r  = $signed(NNW'(s_root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= 1'b0;
        end else if (en) begin
            r_cvld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_chit <= s_side[SW-1];
            r_ca   <= s_side[XW +: 2*W];
            r_nn   <= w_nb - w_r;
            r_nf   <= w_nb + w_r;
        end
    end

    rusi_div #(.W(W), .F(F)) u_div_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_cvld),
        .i_hit   (r_chit),
        .i_num   (r_nn),
        .i_a     (r_ca),
        .o_vld   (d_vld),
        .o_hit   (d_hit),
        .o_q     (d_near)
    );

    rusi_div #(.W(W), .F(F)) u_div_far (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_cvld),
        .i_hit   (r_chit),
        .i_num   (r_nf),
        .i_a     (r_ca),
        .o_vld   (),
        .o_hit   (),
        .o_q     (d_far)
    );

    assign m_axis_tvalid = d_vld;
    assign m_axis_tuser  = d_hit;
    assign m_axis_tdata  = OW'({d_far, d_near});

endmodule : ray_unit_sphere_intersect_core

`default_nettype wire

// File: sv/rusi_quad.sv
// ----------------------------------------------------------------------------
// rusi_quad
// Four-stage front end: dot products, A/B/C, split partial products of
// B*B and A*C, discriminant and radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module rusi_quad #(
    parameter int W = rusi_pkg::WORD_BITS_DEF,
    parameter int F = rusi_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic signed [W-1:0]                   i_org [3],
    input  logic signed [W-1:0]                   i_dir [3],
    output logic                                  o_vld,
    output logic                                  o_hit,
    output logic [rusi_pkg::nw(W, F)-1:0]         o_n,
    output logic [2*W-1:0]                        o_a,
    output logic signed [rusi_pkg::xw(W)-1:0]     o_b
);
    import rusi_pkg::*;

    localparam int XW = xw(W);
    localparam int DW = dw(W);
    localparam int NW = nw(W, F);
    localparam int PW = 2 * W + 2;
    localparam logic signed [XW-1:0] ONE = XW'(1) << (2 * F);

    // valid bits of stages 1..4
    logic [3:0] r_vld;

    // stage 1: the nine products
    logic signed [2*W-1:0] r_pa [3];
    logic signed [2*W-1:0] r_pb [3];
    logic signed [2*W-1:0] r_pc [3];

    // stage 2: A, B, C
    logic signed [XW-1:0] r_a2, r_b2, r_c2;
    logic signed [XW-1:0] n_a2, n_b2, n_c2;

    // stage 3: partial products on the W-bit low and (W+1)-bit high halves
    logic signed [PW-1:0] r_bhh, r_bhl, r_bll, r_ahh, r_ahl, r_alh, r_all;
    logic signed [XW-1:0] r_a3, r_b3;
    logic signed [W:0]    w_ah, w_al, w_bh, w_bl, w_ch, w_cl;

    // stage 4: discriminant
    logic signed [DW-1:0] w_d;
    logic                 w_pos;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= i_dir[i] * i_dir[i];
                r_pb[i] <= i_org[i] * i_dir[i];
                r_pc[i] <= i_org[i] * i_org[i];
            end
        end
    end

    // stage 2
    always_comb begin
        n_a2 = XW'(r_pa[0]) + XW'(r_pa[1]) + XW'(r_pa[2]);
        n_b2 = XW'(r_pb[0]) + XW'(r_pb[1]) + XW'(r_pb[2]);
        n_c2 = XW'(r_pc[0]) + XW'(r_pc[1]) + XW'(r_pc[2]) - ONE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2 <= n_a2;
            r_b2 <= n_b2;
            r_c2 <= n_c2;
        end
    end

    // stage 3: high half signed, low half as a non-negative signed value
    assign w_ah = $signed(r_a2[XW-1:W]);
    assign w_al = $signed({1'b0, r_a2[W-1:0]});
    assign w_bh = $signed(r_b2[XW-1:W]);
    assign w_bl = $signed({1'b0, r_b2[W-1:0]});
    assign w_ch = $signed(r_c2[XW-1:W]);
    assign w_cl = $signed({1'b0, r_c2[W-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bhh <= w_bh * w_bh;
            r_bhl <= w_bh * w_bl;
            r_bll <= w_bl * w_bl;
            r_ahh <= w_ah * w_ch;
            r_ahl <= w_ah * w_cl;
            r_alh <= w_al * w_ch;
            r_all <= w_al * w_cl;
            r_a3  <= r_a2;
            r_b3  <= r_b2;
        end
    end

    // stage 4: D = B*B - A*C, radicand D << 2F on a hit
    always_comb begin
        w_d = (DW'(r_bhh) <<< (2 * W)) + (DW'(r_bhl) <<< (W + 1)) + DW'(r_bll)
            - (DW'(r_ahh) <<< (2 * W)) - ((DW'(r_ahl) + DW'(r_alh)) <<< W)
            - DW'(r_all);
        w_pos = !w_d[DW-1] && (w_d != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit <= w_pos;
            o_n   <= w_pos ? (NW'(w_d[DW-2:0]) << (2 * F)) : '0;
            o_a   <= r_a3[2*W-1:0];
            o_b   <= r_b3;
        end
    end

    assign o_vld = r_vld[3];

endmodule : rusi_quad

`default_nettype wire

// File: sv/rusi_sqrt.sv
// ----------------------------------------------------------------------------
// rusi_sqrt
// Pipelined integer square root, one result bit per stage, with a side
// band that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rusi_sqrt #(
    parameter int W  = rusi_pkg::WORD_BITS_DEF,
    parameter int F  = rusi_pkg::FRAC_BITS_DEF,
    parameter int SW = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [rusi_pkg::nw(W, F)-1:0]     i_n,
    input  logic [SW-1:0]                     i_side,
    output logic                              o_vld,
    output logic [rusi_pkg::rw(W, F)-1:0]     o_root,
    output logic [SW-1:0]                     o_side
);
    import rusi_pkg::*;

    localparam int NW = nw(W, F);
    localparam int RW = rw(W, F);

    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [NW-1:0] r_n    [RW];
    logic [SW-1:0] r_side [RW];
    logic [RW-1:0] r_vld;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RW-2:0], i_vld};
        end
    end

    // one root bit per stage, radicand consumed two bits at a time from the top
    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [RW+1:0] p_rem;
        logic [RW-1:0] p_root;
        logic [NW-1:0] p_n;
        logic [SW-1:0] p_side;
        logic [RW+1:0] n_sh, n_trial, n_rem;
        logic [RW-1:0] n_root;
        logic          n_ge;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_n    = i_n;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_n    = r_n[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            n_sh    = {p_rem[RW-1:0], p_n[NW-1 -: 2]};
            n_trial = {p_root, 2'b01};
            n_ge    = (n_sh >= n_trial);
            n_rem   = n_ge ? (n_sh - n_trial) : n_sh;
            n_root  = {p_root[RW-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_n[g]    <= p_n << 2;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule : rusi_sqrt

`default_nettype wire

// File: sv/rusi_div.sv
// ----------------------------------------------------------------------------
// rusi_div
// Pipelined floor division of a signed numerator by A > 0, one quotient
// bit per stage, saturated to the signed word range; zero on a miss.
// ----------------------------------------------------------------------------
`default_nettype none

module rusi_div #(
    parameter int W = rusi_pkg::WORD_BITS_DEF,
    parameter int F = rusi_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic                                  i_hit,
    input  logic signed [rusi_pkg::nnw(W, F)-1:0] i_num,
    input  logic [2*W-1:0]                        i_a,
    output logic                                  o_vld,
    output logic                                  o_hit,
    output logic signed [W-1:0]                   o_q
);
    import rusi_pkg::*;

    localparam int NNW = nnw(W, F);
    localparam int MW  = NNW - 1;
    localparam int AU  = 2 * W;
    localparam int HW  = MW - W;
    localparam int CW  = (HW > AU) ? HW : AU;
    localparam logic signed [W+1:0] MAXV = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] MINV = {3'b111, {(W-1){1'b0}}};

    // stage 0 is the setup, stages 1..W produce quotient bits
    logic [AU-1:0] r_rem [W+1];
    logic [W-1:0]  r_lo  [W+1];
    logic [W-1:0]  r_q   [W+1];
    logic [AU-1:0] r_a   [W+1];
    logic [W:0]    r_neg, r_ovf, r_hit, r_vld;
    logic          r_ovld;

    logic [NNW-1:0] w_abs;
    logic [MW-1:0]  w_mag;
    logic           w_neg;

    logic signed [W+1:0] w_qx, w_val;
    logic                w_rnz;
    logic signed [W-1:0] w_res;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_vld  <= {r_vld[W-1:0], i_vld};
            r_ovld <= r_vld[W];
        end
    end

    // setup: magnitude, overflow check, top part of the partial remainder
    assign w_neg = i_num[NNW-1];
    assign w_abs = w_neg ? -i_num : i_num;
    assign w_mag = w_abs[MW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= w_neg;
            r_ovf[0] <= (CW'(w_mag >> W) >= CW'(i_a));
            r_hit[0] <= i_hit;
            r_rem[0] <= AU'(w_mag >> W);
            r_lo[0]  <= w_mag[W-1:0];
            r_q[0]   <= '0;
            r_a[0]   <= i_a;
        end
    end

    // restoring division steps
    for (genvar g = 1; g <= W; g++) begin : g_step
        logic [AU:0]   n_sh;
        logic          n_ge;
        logic [AU-1:0] n_rem;

        always_comb begin
            n_sh  = {r_rem[g-1], r_lo[g-1][W-1]};
            n_ge  = (n_sh >= {1'b0, r_a[g-1]});
            n_rem = n_ge ? AU'(n_sh - {1'b0, r_a[g-1]}) : n_sh[AU-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_lo[g]  <= r_lo[g-1] << 1;
                r_q[g]   <= {r_q[g-1][W-2:0], n_ge};
                r_a[g]   <= r_a[g-1];
                r_neg[g] <= r_neg[g-1];
                r_ovf[g] <= r_ovf[g-1];
                r_hit[g] <= r_hit[g-1];
            end
        end
    end

    // round toward minus infinity, then clamp
    always_comb begin
        w_qx  = $signed({2'b00, r_q[W]});
        w_rnz = (r_rem[W] != '0);
        w_val = r_neg[W] ? (-w_qx - (W+2)'(w_rnz)) : w_qx;
        priority if (!r_hit[W]) begin
            w_res = '0;
        end else if (r_ovf[W]) begin
            w_res = r_neg[W] ? MINV[W-1:0] : MAXV[W-1:0];
        end else if (w_val > MAXV) begin
            w_res = MAXV[W-1:0];
        end else if (w_val < MINV) begin
            w_res = MINV[W-1:0];
        end else begin
            w_res = w_val[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q   <= w_res;
            o_hit <= r_hit[W];
        end
    end

    assign o_vld = r_ovld;

endmodule : rusi_div

`default_nettype wire

// File: sv/rusi_chk.sv
// ----------------------------------------------------------------------------
// rusi_chk
// Port-level checks for the intersect core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rusi_chk #(
    parameter int W = rusi_pkg::WORD_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [((2*W+7)/8)*8-1:0]       m_axis_tdata,
    input logic                           m_axis_tuser
);

    // a waiting result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // the input side only stalls behind a stalled result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output");

    // misses carry zero parameters
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss with nonzero parameters");

    // near never exceeds far
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser
        |-> $signed(m_axis_tdata[W-1:0]) <= $signed(m_axis_tdata[2*W-1:W]))
        else $error("near parameter above far parameter");

endmodule : rusi_chk

bind ray_unit_sphere_intersect_core rusi_chk #(.W(WORD_BITS)) u_rusi_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray / unit sphere intersect core: rays go in on
// the slave stream, each result is predicted with exact wide-integer math and
// compared field by field with what comes out of the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int F = rusi_pkg::FRAC_BITS_DEF;
    localparam int ONE = 1 << F;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 250;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;
    localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;

    typedef struct {
        logic        hit;
        logic [31:0] near_t;
        logic [31:0] far_t;
    } t_hit;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;

    t_hit hits_pending[$];
    int   errors = 0;
    int   cycles = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   recv_hold = 0;

    ray_unit_sphere_intersect_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // near_t, far_t
        .m_axis_tuser  (m_axis_tuser)    // hit
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor(n / a) for a > 0, clamped to the signed word range
    function automatic logic [31:0] floor_div_sat(input logic signed [191:0] n,
                                                  input logic signed [191:0] a);
        logic signed [191:0] q;
        q = n / a;
        if ((n % a) != 0 && n < 0) q = q - 1;
        if (q > SMAX) return SMAX;
        if (q < SMIN) return SMIN;
        return q[31:0];
    endfunction

    // exact intersection of one ray with the unit sphere
    function automatic t_hit sphere_hit(input logic signed [31:0] ox, oy, oz,
                                        input logic signed [31:0] dx, dy, dz);
        logic signed [191:0] a, b, c, disc, nb;
        logic [191:0]        rad, root, cand;
        t_hit                r;
        a = 192'(dx) * dx + 192'(dy) * dy + 192'(dz) * dz;
        b = 192'(ox) * dx + 192'(oy) * dy + 192'(oz) * dz;
        c = 192'(ox) * ox + 192'(oy) * oy + 192'(oz) * oz - (192'sd1 <<< (2 * F));
        disc = b * b - a * c;
        r = '{1'b0, 32'd0, 32'd0};
        if (disc > 0) begin
            rad = disc <<< (2 * F);
            root = '0;
            for (int k = 95; k >= 0; k--) begin
                cand = root | (192'd1 << k);
                if (cand * cand <= rad) root = cand;
            end
            nb = (-b) <<< F;
            r.hit = 1'b1;
            r.near_t = floor_div_sat(nb - $signed(root), a);
            r.far_t = floor_div_sat(nb + $signed(root), a);
        end
        return r;
    endfunction

    // one ray transfer; returns just after the transfer edge with tvalid still high
    task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dz, dy, dx, oz, oy, ox};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        hits_pending.push_back(sphere_hit(ox, oy, oz, dx, dy, dz));
    endtask

    function automatic logic [31:0] rand_coord(input int span);
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? SMIN : SMAX;
            2: return 32'($signed($urandom_range(64)) - 32);
            default: return 32'($signed($urandom_range(2 * span * ONE)) - span * ONE);
        endcase
    endfunction

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++)
            send_ray(rand_coord(3), rand_coord(3), rand_coord(3),
                     rand_coord(2), rand_coord(2), rand_coord(2));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // corners: center, tangent, zero direction, extremes, saturation
    task automatic test_directed();
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(0, 0, 0, ONE, 0, 0);
        send_ray(0, 0, -2 * ONE, 0, 0, ONE);
        send_ray(0, ONE, 0, ONE, 0, 0);
        send_ray(0, ONE, -ONE, 0, 0, ONE);
        send_ray(3 * ONE, 0, 0, 0, 0, 0);
        send_ray(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
        send_ray(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
        send_ray(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
        send_ray(0, 0, 0, 1, 0, 0);
        send_ray(0, 0, 0, 0, 0, -1);
        send_ray(ONE / 2, 0, 0, 1, 1, 1);
        send_ray(SMIN, 0, 0, ONE, 0, 0);
        send_ray(SMAX, 0, 0, SMIN, 0, 0);
        send_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        send_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_ray(32'h5555_5555, 32'haaaa_aaaa, 0, 32'haaaa_aaaa, 32'h5555_5555, 0);
        send_ray(0, 0, ONE - 1, ONE, 0, 0);
        wait_drained();
    endtask

    task automatic test_random_idle();
        send_idle_pct = 36; recv_idle_pct = 46;
        send_random(220);
        send_idle_pct = 46; recv_idle_pct = 36;
        send_random(220);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_random(160);
        wait_drained();
    endtask

    // output held off long enough to fill the pipeline and stall the input
    task automatic test_backpressure();
        send_idle_pct = 0; recv_idle_pct = 10;
        recv_hold = 400;
        send_random(150);
        wait_drained();
    endtask

    // result check, sampled at the falling edge before the transfer edge
    always @(negedge i_clk) begin
        t_hit e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hits_pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h hit %b",
                                           m_axis_tdata, m_axis_tuser);
            end else begin
                e = hits_pending.pop_front();
                if (e.hit !== m_axis_tuser || e.near_t !== m_axis_tdata[31:0]
                        || e.far_t !== m_axis_tdata[63:32]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp hit %b near %h far %h, got hit %b near %h far %h",
                                 e.hit, e.near_t, e.far_t, m_axis_tuser,
                                 m_axis_tdata[31:0], m_axis_tdata[63:32]);
                end
            end
        end
    end

    // receiver ready: held low in reset, then random idling or a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 20; recv_idle_pct = 20;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_idle();
        test_backpressure();
        if (errors == 0 && hits_pending.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// File: files.f
sv/rusi_pkg.sv
sv/rusi_quad.sv
sv/rusi_sqrt.sv
sv/rusi_div.sv
sv/ray_unit_sphere_intersect_core.sv
sv/rusi_chk.sv
sim/tb.sv
